### rtl/imu_frame_deframer_unit_assert.svh
// Assertion macros for the inertial sensor frame deframer.
// Used by the port checker; needs only a clock and an active-low reset.
`ifndef IMU_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define IMU_FRAME_DEFRAMER_UNIT_ASSERT_SVH

// same-cycle implication
`define IMU_DFR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("imu deframer check failed");

// next-cycle implication
`define IMU_DFR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("imu deframer check failed");

`endif

### rtl/imu_dfr_pkg.sv
// Shared constants, state encoding and control structs of the IMU frame deframer.
// No dependencies.
`default_nettype none

package imu_dfr_pkg;

    localparam int SYNC_LENGTH  = 4;
    localparam int SYNC_RUN_W   = 3;
    localparam int IDX_W        = 6;
    localparam int CHECK_POS    = 33;
    localparam int FIRST_SAMPLE = 9;
    localparam int CHANNELS     = 12;
    localparam int CH_W         = 4;
    localparam int FIRST_WORD   = (FIRST_SAMPLE + 1) / 2;
    localparam int POS_ID       = 0;
    localparam int POS_TIMER_HI = 3;
    localparam int POS_TIMER_LO = 4;

    localparam logic [7:0]            SYNC_BYTE    = 8'hFF;
    localparam logic [7:0]            SUM_SEED     = 8'((SYNC_LENGTH * 255) % 256);
    localparam logic [SYNC_RUN_W-1:0] SYNC_RUN_MAX = {SYNC_RUN_W{1'b1}};

    typedef enum logic [1:0] {
        ST_HUNT,
        ST_CAPTURE,
        ST_READ,
        ST_SHOW
    } dfr_state_t;

    typedef struct packed {
        logic take_byte;
        logic hunting;
        logic rd_en;
        logic chan_inc;
    } dp_cmd_t;

    typedef struct packed {
        logic sync_hit;
        logic frame_end;
        logic last_chan;
    } dp_status_t;

endpackage

`default_nettype wire

### rtl/imu_dfr_datapath.sv
// Datapath: sync counter, byte index, checksum, header registers and sample memory.
// Depends on imu_dfr_pkg.
`default_nettype none

module imu_dfr_datapath
    import imu_dfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [7:0]         rx_byte,
    input  wire dp_cmd_t            cmd,
    output dp_status_t              status,
    output logic [7:0]              message_id,
    output logic [15:0]             sample_timer,
    output logic [CH_W-1:0]         channel,
    output logic signed [15:0]      sample_value,
    output logic                    checksum_ok,
    output logic                    last
);

    logic [SYNC_RUN_W-1:0] sync_run_reg, sync_run_next, sync_run_inc;
    logic [IDX_W-1:0]      idx_reg, idx_next;
    logic [7:0]            sum_reg, sum_next;
    logic [CH_W-1:0]       chan_reg, chan_next;

    logic [7:0]            id_reg;
    logic [15:0]           timer_reg;
    logic [7:0]            hi_reg;
    logic                  ok_reg;
    logic [15:0]           rd_reg;
    logic [15:0]           mem [CHANNELS];

    logic                  capture_byte;
    logic                  in_samples;
    logic                  wr_en;
    logic [CH_W-1:0]       wr_addr;

    assign sync_run_inc = (sync_run_reg == SYNC_RUN_MAX) ? SYNC_RUN_MAX
                                                         : sync_run_reg + 1'b1;

    assign status.sync_hit  = (rx_byte == SYNC_BYTE)
                           && (sync_run_inc >= SYNC_RUN_W'(SYNC_LENGTH));
    assign status.frame_end = (idx_reg == IDX_W'(CHECK_POS));
    assign status.last_chan = (chan_reg == CH_W'(CHANNELS - 1));

    assign capture_byte = cmd.take_byte && !cmd.hunting;
    assign in_samples   = idx_reg inside {[FIRST_SAMPLE:CHECK_POS-1]};
    assign wr_en        = capture_byte && in_samples && !idx_reg[0];
    assign wr_addr      = CH_W'(idx_reg[IDX_W-1:1] - (IDX_W-1)'(FIRST_WORD));

    always_comb
    begin
        sync_run_next = sync_run_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        chan_next     = chan_reg;
        if (cmd.take_byte && cmd.hunting)
        begin
            if (rx_byte != SYNC_BYTE)
                sync_run_next = '0;
            else if (status.sync_hit)
            begin
                sync_run_next = '0;
                idx_next      = '0;
                sum_next      = SUM_SEED;
            end
            else
                sync_run_next = sync_run_inc;
        end
        else if (capture_byte)
        begin
            if (status.frame_end)
            begin
                idx_next  = '0;
                sum_next  = SUM_SEED;
                chan_next = '0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                sum_next = sum_reg + rx_byte;
            end
        end
        if (cmd.chan_inc)
            chan_next = chan_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_run_reg <= '0;
            idx_reg      <= '0;
            sum_reg      <= SUM_SEED;
            chan_reg     <= '0;
        end
        else
        begin
            sync_run_reg <= sync_run_next;
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            chan_reg     <= chan_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (capture_byte)
        begin
            if (idx_reg == IDX_W'(POS_ID))
                id_reg <= rx_byte;
            if (idx_reg == IDX_W'(POS_TIMER_HI))
                timer_reg[15:8] <= rx_byte;
            if (idx_reg == IDX_W'(POS_TIMER_LO))
                timer_reg[7:0] <= rx_byte;
            if (in_samples && idx_reg[0])
                hi_reg <= rx_byte;
            if (status.frame_end)
                ok_reg <= (rx_byte == sum_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= {hi_reg, rx_byte};
        if (cmd.rd_en)
            rd_reg <= mem[chan_reg];
    end

    assign message_id   = id_reg;
    assign sample_timer = timer_reg;
    assign channel      = chan_reg;
    assign sample_value = rd_reg;
    assign checksum_ok  = ok_reg;
    assign last         = status.last_chan;

endmodule

`default_nettype wire

### rtl/imu_dfr_ctrl.sv
// Controller: hunt / capture / result sequencing and handshakes.
// Depends on imu_dfr_pkg.
`default_nettype none

module imu_dfr_ctrl
    import imu_dfr_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    dfr_state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_HUNT:
                if (cmd.take_byte && status.sync_hit)
                    state_next = ST_CAPTURE;
            ST_CAPTURE:
                if (cmd.take_byte && status.frame_end)
                    state_next = ST_READ;
            ST_READ:
                state_next = ST_SHOW;
            ST_SHOW:
                if (out_ready)
                    state_next = status.last_chan ? ST_HUNT : ST_READ;
            default:
                state_next = ST_HUNT;
        endcase
    end

    always_comb
    begin
        in_ready      = (state_reg == ST_HUNT) || (state_reg == ST_CAPTURE);
        out_valid     = (state_reg == ST_SHOW);
        cmd.take_byte = in_valid && in_ready;
        cmd.hunting   = (state_reg == ST_HUNT);
        cmd.rd_en     = (state_reg == ST_READ);
        cmd.chan_inc  = out_valid && out_ready && !status.last_chan;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_HUNT;
        else
            state_reg <= state_next;
    end

endmodule

`default_nettype wire

### rtl/imu_frame_deframer_unit.sv
// Top level of the IMU frame deframer: controller plus datapath.
// Depends on imu_dfr_pkg, imu_dfr_ctrl, imu_dfr_datapath.
//
//   channel   handshake              payload
//   input     in_valid / in_ready    rx_byte
//   output    out_valid / out_ready  message_id, sample_timer, channel,
//                                    sample_value, checksum_ok, last
//
// In hunting and capturing, in_ready is high and a byte is taken whenever in_valid is high.
// The final frame byte starts 12 results, each a sample memory read, then
// present, so input is held off until the last result is taken.
// Reset is asynchronous and returns the block to sync hunting.
`default_nettype none

module imu_frame_deframer_unit
    import imu_dfr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [7:0]         rx_byte,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [7:0]              message_id,
    output logic [15:0]             sample_timer,
    output logic [3:0]              channel,
    output logic signed [15:0]      sample_value,
    output logic                    checksum_ok,
    output logic                    last
);

    dp_cmd_t    cmd;
    dp_status_t status;

    imu_dfr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    imu_dfr_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .rx_byte      (rx_byte),
        .cmd          (cmd),
        .status       (status),
        .message_id   (message_id),
        .sample_timer (sample_timer),
        .channel      (channel),
        .sample_value (sample_value),
        .checksum_ok  (checksum_ok),
        .last         (last)
    );

endmodule

`default_nettype wire

### rtl/imu_dfr_checker.sv
// Port-level checker for the IMU frame deframer, bound to the top level.
// Depends on imu_frame_deframer_unit_assert.svh.
`default_nettype none
`include "imu_frame_deframer_unit_assert.svh"

module imu_dfr_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [7:0]         message_id,
    input wire logic [15:0]        sample_timer,
    input wire logic [3:0]         channel,
    input wire logic signed [15:0] sample_value,
    input wire logic               checksum_ok,
    input wire logic               last
);

    logic        out_wait;
    logic        out_fire;
    logic        last_chan;
    logic [45:0] payload;

    assign out_wait  = out_valid && !out_ready;
    assign out_fire  = out_valid && out_ready;
    assign last_chan = (channel == 4'd11);
    assign payload   = {message_id, sample_timer, channel, sample_value, checksum_ok, last};

    `IMU_DFR_ASSERT_NEXT(a_out_hold, clk, rst_n, out_wait, out_valid && $stable(payload))
    `IMU_DFR_ASSERT_NOW(a_no_input_in_emit, clk, rst_n, out_valid, !in_ready)
    `IMU_DFR_ASSERT_NOW(a_last_on_eleven, clk, rst_n, out_valid, (last == last_chan) && (channel <= 4'd11))
    `IMU_DFR_ASSERT_NEXT(a_hunt_after_last, clk, rst_n, out_fire && last, in_ready && !out_valid)

endmodule

bind imu_frame_deframer_unit imu_dfr_checker u_imu_dfr_checker (.*);

`default_nettype wire

### sim/imu_frame_deframer_unit_tb.sv
// Testbench for imu_frame_deframer_unit: sync hunting, frame capture, checksum and 12 results.
// Needs imu_dfr_pkg and the deframer RTL; directed table first, then random frames and noise.
`default_nettype none

module imu_frame_deframer_unit_tb;
    import imu_dfr_pkg::*;

    typedef struct packed {
        logic [7:0]         id;
        logic [15:0]        timer;
        logic [3:0]         ch;
        logic signed [15:0] val;
        logic               ok;
        logic               last;
    } sample_t;

    typedef enum logic {ROW_BYTE, ROW_FRAME} row_kind_t;

    typedef struct packed {
        row_kind_t          kind;
        logic [3:0]         nsync;
        logic [7:0]         hi;
        logic [7:0]         lo;
        logic [7:0]         chk;
        logic               typed;
        logic [7:0]         id;
        logic [15:0]        timer;
        logic signed [15:0] val;
        logic               ok;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [7:0]         rx_byte = 8'h00;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [7:0]         message_id;
    logic [15:0]        sample_timer;
    logic [3:0]         channel;
    logic signed [15:0] sample_value;
    logic               checksum_ok;
    logic               last;

    imu_frame_deframer_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .message_id   (message_id),
        .sample_timer (sample_timer),
        .channel      (channel),
        .sample_value (sample_value),
        .checksum_ok  (checksum_ok),
        .last         (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sample_t     pending_samples[$];
    int          mismatches = 0;
    int          idle_odds = 2;
    bit          quiet = 1'b0;
    bit          typed_on = 1'b0;
    sample_t     typed_head;

    // deframer prediction state
    logic [SYNC_RUN_W-1:0] hunt_run = '0;
    logic                  in_frame = 1'b0;
    logic [IDX_W-1:0]      frame_pos = '0;
    logic [7:0]            frame_buf [0:CHECK_POS];
    logic [7:0]            frame_sum = SUM_SEED;

    task automatic deframe_byte(input logic [7:0] b);
        sample_t s;
        if (!in_frame)
        begin
            if (b == SYNC_BYTE)
            begin
                if (hunt_run != SYNC_RUN_MAX)
                    hunt_run = hunt_run + 1'b1;
                if (hunt_run >= SYNC_LENGTH)
                begin
                    in_frame  = 1'b1;
                    frame_pos = '0;
                    frame_sum = SUM_SEED;
                end
            end
            else
                hunt_run = '0;
        end
        else
        begin
            frame_buf[frame_pos] = b;
            if (frame_pos < CHECK_POS)
            begin
                frame_sum = frame_sum + b;
                frame_pos = frame_pos + 1'b1;
            end
            else
            begin
                for (int k = 0; k < CHANNELS; k++)
                begin
                    if (typed_on)
                        s = typed_head;
                    else
                    begin
                        s.id    = frame_buf[POS_ID];
                        s.timer = {frame_buf[POS_TIMER_HI], frame_buf[POS_TIMER_LO]};
                        s.val   = {frame_buf[FIRST_SAMPLE + 2*k],
                                   frame_buf[FIRST_SAMPLE + 2*k + 1]};
                        s.ok    = (frame_buf[CHECK_POS] == frame_sum);
                    end
                    s.ch   = 4'(k);
                    s.last = (k == CHANNELS - 1);
                    pending_samples.push_back(s);
                end
                hunt_run  = '0;
                in_frame  = 1'b0;
                frame_pos = '0;
                frame_sum = SUM_SEED;
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        if (!quiet && idle_odds != 0 && $urandom_range(1, 8) <= idle_odds)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (!in_ready);
        deframe_byte(b);
    endtask

    task automatic send_frame(input int nsync, input logic [7:0] body [0:CHECK_POS]);
        repeat (nsync) push_byte(SYNC_BYTE);
        for (int i = 0; i <= CHECK_POS; i++)
            push_byte(body[i]);
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'h80;
            3: return 8'h7F;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic note_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        sample_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $display("%0t: unexpected item, expected none, actual ch %0d value %h",
                         $time, channel, sample_value);
                mismatches++;
            end
            else
            begin
                w = pending_samples.pop_front();
                note_field("message_id", 16'(w.id), 16'(message_id));
                note_field("sample_timer", w.timer, sample_timer);
                note_field("channel", 16'(w.ch), 16'(channel));
                note_field("sample_value", w.val, sample_value);
                note_field("checksum_ok", 16'(w.ok), 16'(checksum_ok));
                note_field("last", 16'(w.last), 16'(last));
            end
        end
    end

    int stall_left = 0;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (quiet)
            out_ready <= 1'b1;
        else if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (idle_odds != 0 && $urandom_range(1, 12) <= idle_odds)
        begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 16);
        end
        else
            out_ready <= 1'b1;
    end

    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= 1000)
        begin
            $display("imu_frame_deframer_unit_tb failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    dir_row_t dir_rows [16];

    initial
    begin : stim
        logic [7:0] body [0:CHECK_POS];
        logic [7:0] sum;
        int         random_bytes;
        int         random_frames;
        int         pick;
        int         n;

        // kind, sync, hi, lo, check, typed, id, timer, value, ok
        dir_rows = '{
            '{ROW_BYTE,  4'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_BYTE,  4'd0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_BYTE,  4'd0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_BYTE,  4'd0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_BYTE,  4'd0, 8'h00, 8'h7E, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_BYTE,  4'd0, 8'h00, 8'hFF, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_BYTE,  4'd0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_FRAME, 4'd4, 8'h00, 8'h00, 8'hFC, 1'b1, 8'h00, 16'h0000, 16'h0000, 1'b1},
            '{ROW_FRAME, 4'd4, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0},
            '{ROW_FRAME, 4'd4, 8'hFF, 8'hFF, 8'hDB, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1},
            '{ROW_FRAME, 4'd4, 8'h7F, 8'hFF, 8'hDB, 1'b1, 8'hFF, 16'h7FFF, 16'h7FFF, 1'b1},
            '{ROW_FRAME, 4'd4, 8'h80, 8'h00, 8'hFC, 1'b1, 8'h00, 16'h8000, 16'h8000, 1'b1},
            '{ROW_FRAME, 4'd4, 8'h80, 8'h00, 8'h00, 1'b1, 8'h00, 16'h8000, 16'h8000, 1'b0},
            '{ROW_FRAME, 4'd7, 8'h5A, 8'hA5, 8'h00, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_FRAME, 4'd3, 8'h12, 8'h34, 8'h56, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0},
            '{ROW_FRAME, 4'd4, 8'hC3, 8'h3C, 8'h99, 1'b0, 8'h00, 16'h0000, 16'h0000, 1'b0}
        };

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[r])
        begin
            if (dir_rows[r].kind == ROW_BYTE)
                push_byte(dir_rows[r].lo);
            else
            begin
                for (int i = 0; i <= CHECK_POS; i++)
                    body[i] = (i == CHECK_POS) ? dir_rows[r].chk :
                              (i % 2 == 1) ? dir_rows[r].hi : dir_rows[r].lo;
                typed_head = '{dir_rows[r].id, dir_rows[r].timer, 4'd0,
                               dir_rows[r].val, dir_rows[r].ok, 1'b0};
                typed_on = dir_rows[r].typed;
                send_frame(dir_rows[r].nsync, body);
                typed_on = 1'b0;
            end
        end

        random_bytes  = 0;
        random_frames = 0;
        while (random_bytes < 120 || random_frames < 2)
        begin
            if (random_bytes >= 80)
                quiet = 1'b1;
            idle_odds = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            pick = $urandom_range(0, 9);
            if (pick <= 5 || pick == 9)
            begin
                sum = SUM_SEED;
                for (int i = 0; i < CHECK_POS; i++)
                begin
                    body[i] = rand_byte();
                    sum = sum + body[i];
                end
                body[CHECK_POS] = ($urandom_range(0, 9) < 6) ? sum : 8'($urandom);
                n = (pick == 9) ? $urandom_range(5, 9) : SYNC_LENGTH;
                send_frame(n, body);
                random_bytes += n + CHECK_POS + 1;
                random_frames++;
            end
            else if (pick == 6)
            begin
                n = $urandom_range(1, 6);
                repeat (n) push_byte(8'($urandom));
                random_bytes += n;
            end
            else if (pick == 7)
            begin
                // sync run cut short
                n = $urandom_range(1, SYNC_LENGTH - 1);
                repeat (n) push_byte(SYNC_BYTE);
                push_byte(8'($urandom_range(0, 254)));
                random_bytes += n + 1;
            end
            else
            begin
                // truncated frame; the following bytes land inside it
                n = $urandom_range(1, 30);
                repeat (SYNC_LENGTH) push_byte(SYNC_BYTE);
                repeat (n) push_byte(rand_byte());
                random_bytes += SYNC_LENGTH + n;
            end
        end

        in_valid <= 1'b0;
        wait (pending_samples.size() == 0);
        repeat (40) @(posedge clk);

        if (mismatches == 0 && pending_samples.size() == 0)
            $display("imu_frame_deframer_unit_tb passed");
        else
            $display("imu_frame_deframer_unit_tb failed");
        $finish;
    end

endmodule

`default_nettype wire
